FILE: design/boundary_tag_heap_allocator_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH

// Concurrent check on the rising clock, suspended while reset is asserted.
`define BTHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check on the rising clock that also holds during reset.
`define BTHA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/btha_pkg.sv
// Types and constants of the boundary-tag heap allocator.
package btha_pkg;

	// The word count must be a power of two; word offsets wrap at it.
	localparam int unsigned HEAP_WORDS_DEF = 65536;
	localparam logic [18:0] CHUNK_RESET = 19'd4096;
	localparam logic [31:0] ALLOC_BIT = 32'h1;
	localparam logic [31:0] PROLOGUE_TAG = 32'h9;

	localparam int unsigned FIELD_W = 18;
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 24;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_INIT0, S_INIT1, S_INIT2, S_INIT3,
		S_EXT_GROW, S_EXT_FTR, S_EXT_EPI,
		S_WALK0, S_WALK,
		S_MRG_R1, S_MRG_R2, S_MRG_R3, S_MRG_R4, S_MRG_R5, S_MRG_DEC,
		S_MRG_PAF, S_MRG_NAR, S_MRG_NAW,
		S_MRG_BOF, S_MRG_BOR1, S_MRG_BOR2, S_MRG_BOW,
		S_MRG_RETR, S_MRG_RET,
		S_PLC_R, S_PLC_H, S_PLC_F, S_PLC_NH, S_PLC_NF,
		S_FREE_R, S_FREE_H, S_FREE_F,
		S_DONE
	} state_t;

endpackage

FILE: design/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator: sequencer around one heap word memory.
//
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      tuser opcode, tdata request_bytes, block_addr
// m_*       out  tvalid/tready      tuser status, tdata result_addr
// cfg_*     in   write enable only  chunk_bytes
//
// One word enters at a time; ready is high only while the sequencer is idle.
// From acceptance, allocate walks the blocks, then places and answers, or grows the heap
// and merges first; free merges the freed block and initialize builds and grows the heap.
// Tag accesses share one heap memory, one access a cycle.
// A held result stalls the sequencer in its final state. Reset clears break, sets chunk
// to its default and idles the state and output valid; the heap memory is not cleared.
module boundary_tag_heap_allocator #(
	parameter int unsigned HEAP_WORDS = btha_pkg::HEAP_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// bits: request_bytes[17:0], block_addr[35:18], zero fill
	input  logic [btha_pkg::S_TDATA_W-1:0] s_tdata,
	// bits: opcode[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// bits: result_addr[17:0], zero fill
	output logic [btha_pkg::M_TDATA_W-1:0] m_tdata,
	// bits: status[1:0]
	output logic [1:0]                     m_tuser,
	input  logic                           cfg_we,
	input  logic [18:0]                    cfg_wdata
);

	localparam int unsigned AW = $clog2(HEAP_WORDS);
	localparam int unsigned BW = AW + 3;
	localparam int unsigned NW = AW + 1;
	localparam logic [BW-1:0] MEM_BYTES = BW'(HEAP_WORDS) << 2;
	localparam logic [NW-1:0] HW_N = NW'(HEAP_WORDS);

	btha_pkg::state_t state_q, state_d;

	logic [31:0] mem [HEAP_WORDS];
	logic [31:0] rdata_q;
	logic        rd_en, wr_en;
	logic [31:0] rd_off, wr_off, wr_data;

	logic [BW-1:0] break_q;
	logic [18:0]   chunk_q;
	logic          m_tvalid_q;
	logic [17:0]   out_addr_q;
	logic [1:0]    out_status_q;

	logic          alloc_q, pa_q, eq_q, have_q;
	logic [18:0]   asize_q;
	logic [19:0]   bytes_q;
	logic [31:0]   bp_q, pf_q, b_q, s0_q, nx_q, s_q, rest_q, best_q, where_q;
	logic [32:0]   wbp_q;
	logic [NW-1:0] n_q;
	logic [17:0]   res_q;
	logic [1:0]    status_q;

	logic [31:0] rsize;
	logic        ralloc;
	logic [19:0] chunk_rnd, chunk_eff;
	logic [17:0] in_req, in_blk;
	logic [18:0] in_req_pad, in_asize;
	logic [31:0] asize32, bytes32, brk32;
	logic [32:0] grow_sum;
	logic        grow_ok;
	logic        free_ok, accept, out_free, merge_pa, merge_na;
	logic        w_fit, w_cont, have_n;
	logic [31:0] where_n;
	logic [32:0] w_nbp;
	logic [NW-1:0] w_nn;
	logic [19:0] ext_bytes;
	btha_pkg::state_t fin_state;

	assign rsize  = {rdata_q[31:3], 3'b000};
	assign ralloc = rdata_q[0];

	assign chunk_rnd = ({1'b0, chunk_q} + 20'd7) & ~20'd7;
	assign chunk_eff = (chunk_rnd < 20'd16) ? 20'd16 : chunk_rnd;

	assign in_req     = s_tdata[17:0];
	assign in_blk     = s_tdata[35:18];
	assign in_req_pad = {1'b0, in_req} + 19'd15;
	assign in_asize   = (in_req <= 18'd8) ? 19'd16 : (in_req_pad & ~19'd7);

	assign asize32 = {13'd0, asize_q};
	assign bytes32 = {12'd0, bytes_q};
	assign brk32   = 32'(break_q);

	assign grow_sum = {1'b0, brk32} + {1'b0, bytes32};
	assign grow_ok  = grow_sum <= 33'(MEM_BYTES);

	assign free_ok = (break_q != '0) && (in_blk[2:0] == 3'b000) && (in_blk >= 18'd8)
		&& ({14'd0, in_blk} < brk32);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign merge_pa = pa_q;
	assign merge_na = ralloc;

	// Best-fit walk: one header consumed per cycle while the next is being read.
	assign w_fit   = (rsize != 32'd0) && !ralloc && (rsize >= asize32)
		&& (!have_q || (rsize < best_q));
	assign w_nbp   = wbp_q + {1'b0, rsize};
	assign w_nn    = n_q + NW'(1);
	assign w_cont  = (rsize != 32'd0) && (w_nn < HW_N) && (w_nbp <= {1'b0, brk32});
	assign have_n  = have_q || w_fit;
	assign where_n = w_fit ? wbp_q[31:0] : where_q;
	assign ext_bytes = ({1'b0, asize_q} > chunk_eff) ? {1'b0, asize_q} : chunk_eff;

	assign fin_state = alloc_q ? btha_pkg::S_PLC_R : btha_pkg::S_DONE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btha_pkg::S_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						btha_pkg::OP_INIT:  state_d = btha_pkg::S_INIT0;
						btha_pkg::OP_ALLOC: begin
							if (in_req == '0 || break_q == '0) state_d = btha_pkg::S_DONE;
							else state_d = btha_pkg::S_WALK0;
						end
						btha_pkg::OP_FREE:  state_d = free_ok ? btha_pkg::S_FREE_R : btha_pkg::S_DONE;
						default:            state_d = btha_pkg::S_DONE;
					endcase
				end
			end
			btha_pkg::S_INIT0:    state_d = btha_pkg::S_INIT1;
			btha_pkg::S_INIT1:    state_d = btha_pkg::S_INIT2;
			btha_pkg::S_INIT2:    state_d = btha_pkg::S_INIT3;
			btha_pkg::S_INIT3:    state_d = btha_pkg::S_EXT_GROW;
			btha_pkg::S_EXT_GROW: state_d = grow_ok ? btha_pkg::S_EXT_FTR : btha_pkg::S_DONE;
			btha_pkg::S_EXT_FTR:  state_d = btha_pkg::S_EXT_EPI;
			btha_pkg::S_EXT_EPI:  state_d = btha_pkg::S_MRG_R1;
			btha_pkg::S_WALK0:    state_d = btha_pkg::S_WALK;
			btha_pkg::S_WALK: begin
				if (!w_cont) state_d = have_n ? btha_pkg::S_PLC_R : btha_pkg::S_EXT_GROW;
			end
			btha_pkg::S_MRG_R1:   state_d = btha_pkg::S_MRG_R2;
			btha_pkg::S_MRG_R2:   state_d = btha_pkg::S_MRG_R3;
			btha_pkg::S_MRG_R3:   state_d = btha_pkg::S_MRG_R4;
			btha_pkg::S_MRG_R4:   state_d = btha_pkg::S_MRG_R5;
			btha_pkg::S_MRG_R5:   state_d = btha_pkg::S_MRG_DEC;
			btha_pkg::S_MRG_DEC: begin
				if (merge_pa && merge_na) state_d = fin_state;
				else if (merge_pa) state_d = btha_pkg::S_MRG_PAF;
				else if (merge_na) state_d = btha_pkg::S_MRG_NAR;
				else state_d = btha_pkg::S_MRG_BOF;
			end
			btha_pkg::S_MRG_PAF:  state_d = fin_state;
			btha_pkg::S_MRG_NAR:  state_d = btha_pkg::S_MRG_NAW;
			btha_pkg::S_MRG_NAW:  state_d = btha_pkg::S_MRG_RETR;
			btha_pkg::S_MRG_BOF:  state_d = btha_pkg::S_MRG_BOR1;
			btha_pkg::S_MRG_BOR1: state_d = btha_pkg::S_MRG_BOR2;
			btha_pkg::S_MRG_BOR2: state_d = btha_pkg::S_MRG_BOW;
			btha_pkg::S_MRG_BOW:  state_d = btha_pkg::S_MRG_RETR;
			btha_pkg::S_MRG_RETR: state_d = btha_pkg::S_MRG_RET;
			btha_pkg::S_MRG_RET:  state_d = fin_state;
			btha_pkg::S_PLC_R:    state_d = btha_pkg::S_PLC_H;
			btha_pkg::S_PLC_H:    state_d = btha_pkg::S_PLC_F;
			btha_pkg::S_PLC_F:    state_d = eq_q ? btha_pkg::S_DONE : btha_pkg::S_PLC_NH;
			btha_pkg::S_PLC_NH:   state_d = btha_pkg::S_PLC_NF;
			btha_pkg::S_PLC_NF:   state_d = btha_pkg::S_DONE;
			btha_pkg::S_FREE_R:   state_d = btha_pkg::S_FREE_H;
			btha_pkg::S_FREE_H:   state_d = btha_pkg::S_FREE_F;
			btha_pkg::S_FREE_F:   state_d = btha_pkg::S_MRG_R1;
			btha_pkg::S_DONE:     state_d = out_free ? btha_pkg::S_IDLE : btha_pkg::S_DONE;
			default:              state_d = btha_pkg::S_IDLE;
		endcase
	end

	// Memory accesses of each step; a read issued here returns in the next state.
	always_comb begin
		rd_en   = 1'b0;
		rd_off  = '0;
		wr_en   = 1'b0;
		wr_off  = '0;
		wr_data = '0;
		unique case (state_q)
			btha_pkg::S_INIT0: begin
				wr_en = 1'b1; wr_off = 32'd0; wr_data = 32'd0;
			end
			btha_pkg::S_INIT1: begin
				wr_en = 1'b1; wr_off = 32'd4; wr_data = btha_pkg::PROLOGUE_TAG;
			end
			btha_pkg::S_INIT2: begin
				wr_en = 1'b1; wr_off = 32'd8; wr_data = btha_pkg::PROLOGUE_TAG;
			end
			btha_pkg::S_INIT3: begin
				wr_en = 1'b1; wr_off = 32'd12; wr_data = btha_pkg::ALLOC_BIT;
			end
			btha_pkg::S_EXT_GROW: begin
				wr_en = grow_ok; wr_off = brk32 - 32'd4; wr_data = bytes32;
			end
			btha_pkg::S_EXT_FTR: begin
				wr_en = 1'b1; wr_off = bp_q + bytes32 - 32'd8; wr_data = bytes32;
			end
			btha_pkg::S_EXT_EPI: begin
				wr_en = 1'b1; wr_off = bp_q + bytes32 - 32'd4; wr_data = btha_pkg::ALLOC_BIT;
			end
			btha_pkg::S_WALK0: begin
				rd_en = 1'b1; rd_off = wbp_q[31:0] - 32'd4;
			end
			btha_pkg::S_WALK: begin
				rd_en = w_cont; rd_off = w_nbp[31:0] - 32'd4;
			end
			btha_pkg::S_MRG_R1: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd8;
			end
			btha_pkg::S_MRG_R2: begin
				rd_en = 1'b1; rd_off = bp_q - rsize - 32'd4;
			end
			btha_pkg::S_MRG_R3: begin
				rd_en = 1'b1; rd_off = pf_q + rsize - 32'd8;
			end
			btha_pkg::S_MRG_R4: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd4;
			end
			btha_pkg::S_MRG_R5: begin
				rd_en = 1'b1; rd_off = bp_q + rsize - 32'd4;
			end
			btha_pkg::S_MRG_DEC: begin
				if (merge_pa && !merge_na) begin
					wr_en = 1'b1; wr_off = bp_q - 32'd4; wr_data = s0_q + rsize;
				end else if (!merge_pa && merge_na) begin
					wr_en = 1'b1; wr_off = bp_q + s0_q - 32'd8; wr_data = s0_q + b_q;
				end else if (!merge_pa && !merge_na) begin
					rd_en = 1'b1; rd_off = nx_q + rsize - 32'd8;
				end
			end
			btha_pkg::S_MRG_PAF: begin
				wr_en = 1'b1; wr_off = bp_q + s_q - 32'd8; wr_data = s_q;
			end
			btha_pkg::S_MRG_NAR: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd8;
			end
			btha_pkg::S_MRG_NAW: begin
				wr_en = 1'b1; wr_off = bp_q - rsize - 32'd4; wr_data = s_q;
			end
			btha_pkg::S_MRG_BOF: begin
				wr_en = 1'b1; wr_off = pf_q - 32'd4; wr_data = s0_q + b_q + rsize;
			end
			btha_pkg::S_MRG_BOR1: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd4;
			end
			btha_pkg::S_MRG_BOR2: begin
				rd_en = 1'b1; rd_off = bp_q + rsize - 32'd4;
			end
			btha_pkg::S_MRG_BOW: begin
				wr_en = 1'b1; wr_off = nx_q + rsize - 32'd8; wr_data = s_q;
			end
			btha_pkg::S_MRG_RETR: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd8;
			end
			btha_pkg::S_PLC_R: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd4;
			end
			btha_pkg::S_PLC_H: begin
				wr_en = 1'b1; wr_off = bp_q - 32'd4; wr_data = asize32 | btha_pkg::ALLOC_BIT;
			end
			btha_pkg::S_PLC_F: begin
				wr_en = 1'b1; wr_off = bp_q + asize32 - 32'd8;
				wr_data = asize32 | btha_pkg::ALLOC_BIT;
			end
			btha_pkg::S_PLC_NH: begin
				wr_en = 1'b1; wr_off = bp_q + asize32 - 32'd4; wr_data = rest_q;
			end
			btha_pkg::S_PLC_NF: begin
				wr_en = 1'b1; wr_off = nx_q; wr_data = rest_q;
			end
			btha_pkg::S_FREE_R: begin
				rd_en = 1'b1; rd_off = bp_q - 32'd4;
			end
			btha_pkg::S_FREE_H: begin
				wr_en = 1'b1; wr_off = bp_q - 32'd4; wr_data = rsize;
			end
			btha_pkg::S_FREE_F: begin
				wr_en = 1'b1; wr_off = bp_q + s_q - 32'd8; wr_data = s_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_off[AW+1:2]] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[rd_off[AW+1:2]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= btha_pkg::S_IDLE;
			break_q    <= '0;
			chunk_q    <= btha_pkg::CHUNK_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) chunk_q <= cfg_wdata;
			// Initialize restarts the heap with the four fixed words already counted.
			if (accept && s_tuser == btha_pkg::OP_INIT) break_q <= BW'(16);
			else if (state_q == btha_pkg::S_EXT_GROW && grow_ok) break_q <= break_q + BW'(bytes_q);
			if (state_q == btha_pkg::S_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			btha_pkg::S_IDLE: begin
				if (accept) begin
					alloc_q  <= (s_tuser == btha_pkg::OP_ALLOC);
					asize_q  <= in_asize;
					bytes_q  <= chunk_eff;
					bp_q     <= {14'd0, in_blk};
					wbp_q    <= 33'd8;
					n_q      <= '0;
					have_q   <= 1'b0;
					best_q   <= '0;
					where_q  <= '0;
					res_q    <= '0;
					status_q <= btha_pkg::ST_OK;
					if (s_tuser == btha_pkg::OP_ALLOC) begin
						if (in_req == '0) status_q <= btha_pkg::ST_ZERO;
						else if (break_q == '0) status_q <= btha_pkg::ST_OOM;
					end
				end
			end
			btha_pkg::S_EXT_GROW: begin
				bp_q <= brk32;
				if (!grow_ok) status_q <= btha_pkg::ST_OOM;
			end
			btha_pkg::S_WALK: begin
				have_q  <= have_n;
				where_q <= where_n;
				if (w_fit) best_q <= rsize;
				wbp_q <= w_nbp;
				n_q   <= w_nn;
				if (!w_cont) begin
					if (have_n) bp_q <= where_n;
					else bytes_q <= ext_bytes;
				end
			end
			btha_pkg::S_MRG_R2: pf_q <= bp_q - rsize;
			btha_pkg::S_MRG_R3: b_q <= rsize;
			btha_pkg::S_MRG_R4: pa_q <= ralloc;
			btha_pkg::S_MRG_R5: begin
				s0_q <= rsize;
				nx_q <= bp_q + rsize;
			end
			btha_pkg::S_MRG_DEC: begin
				if (merge_pa && !merge_na) s_q <= s0_q + rsize;
				else if (!merge_pa && merge_na) s_q <= s0_q + b_q;
			end
			btha_pkg::S_MRG_BOF:  s_q <= s0_q + b_q + rsize;
			btha_pkg::S_MRG_BOR2: nx_q <= bp_q + rsize;
			btha_pkg::S_MRG_RET:  bp_q <= bp_q - rsize;
			btha_pkg::S_PLC_R:    res_q <= bp_q[17:0];
			btha_pkg::S_PLC_H: begin
				rest_q <= rsize - asize32;
				eq_q   <= (rsize == asize32);
				nx_q   <= bp_q + rsize - 32'd8;
			end
			btha_pkg::S_FREE_H: s_q <= rsize;
			btha_pkg::S_DONE: begin
				if (out_free) begin
					out_addr_q   <= res_q;
					out_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == btha_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_addr_q};
	assign m_tuser  = out_status_q;

endmodule

FILE: design/btha_check.sv
// Port-level checker for the heap allocator, bound to the top level.
`include "boundary_tag_heap_allocator_macros.svh"

module btha_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [btha_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);

	// A held result keeps its contents until it is taken.
	`BTHA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// The sequencer is busy in the cycle after it takes a word.
	`BTHA_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready, "second word taken back to back")

	// A zero-size request never returns an address.
	`BTHA_ASSERT(a_zero, m_tvalid && m_tuser == btha_pkg::ST_ZERO |-> m_tdata[17:0] == 18'd0, "zero-size request returned an address")

	// Payload offsets handed out are always double-word aligned.
	`BTHA_ASSERT_ALWAYS(a_align, m_tvalid && m_tuser == btha_pkg::ST_OK |-> m_tdata[2:0] == 3'b000, "misaligned payload offset")

endmodule

bind boundary_tag_heap_allocator btha_check u_btha_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: verif/heap_alloc_checker.sv
// Checker for the heap allocator: tracks the heap, predicts each result and compares.
module heap_alloc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [btha_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]                     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [btha_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [1:0]                     m_tuser,
	input  logic                           cfg_we,
	input  logic [18:0]                    cfg_wdata,
	output int                             errors,
	output int                             pending
);

	localparam longint HEAP_BYTES = longint'(btha_pkg::HEAP_WORDS_DEF) * 4;
	localparam int unsigned SIZE_MASK = 32'hFFFF_FFF8;

	typedef struct packed {
		logic [17:0]       addr;
		btha_pkg::status_t st;
	} alloc_result_t;

	logic [31:0]    heap_m [0:btha_pkg::HEAP_WORDS_DEF-1];
	int unsigned    brk;
	logic [18:0]    chunk;
	alloc_result_t  results_due [$];

	initial errors = 0;
	initial pending = 0;

	function automatic int unsigned rdw(input int unsigned off);
		return heap_m[(off >> 2) % btha_pkg::HEAP_WORDS_DEF];
	endfunction

	function automatic void wrw(input int unsigned off, input int unsigned v);
		heap_m[(off >> 2) % btha_pkg::HEAP_WORDS_DEF] = v;
	endfunction

	function automatic int unsigned tsize(input int unsigned off);
		return rdw(off) & SIZE_MASK;
	endfunction

	function automatic int unsigned talloc(input int unsigned off);
		return rdw(off) & btha_pkg::ALLOC_BIT;
	endfunction

	function automatic int unsigned foot_at(input int unsigned bp);
		return bp + tsize(bp - 4) - 8;
	endfunction

	function automatic int unsigned next_bp(input int unsigned bp);
		return bp + tsize(bp - 4);
	endfunction

	function automatic int unsigned prev_bp(input int unsigned bp);
		return bp - tsize(bp - 8);
	endfunction

	function automatic int unsigned coalesce(input int unsigned bp);
		int unsigned pa, na, s;
		pa = talloc(foot_at(prev_bp(bp)));
		na = talloc(next_bp(bp) - 4);
		s = tsize(bp - 4);
		if (pa != 0 && na != 0)
			return bp;
		if (pa != 0) begin
			s += tsize(next_bp(bp) - 4);
			wrw(bp - 4, s);
			wrw(foot_at(bp), s);
		end else if (na != 0) begin
			s += tsize(prev_bp(bp) - 4);
			wrw(foot_at(bp), s);
			wrw(prev_bp(bp) - 4, s);
			bp = prev_bp(bp);
		end else begin
			s += tsize(prev_bp(bp) - 4) + tsize(foot_at(next_bp(bp)));
			wrw(prev_bp(bp) - 4, s);
			wrw(foot_at(next_bp(bp)), s);
			bp = prev_bp(bp);
		end
		return bp;
	endfunction

	function automatic bit grow_break(input int unsigned bytes, output int unsigned old);
		old = brk;
		if (longint'(brk) + longint'(bytes) > HEAP_BYTES)
			return 0;
		brk += bytes;
		return 1;
	endfunction

	function automatic bit append_block(input int unsigned bytes, output int unsigned bp_out);
		int unsigned bp;
		bp_out = 0;
		if (!grow_break(bytes, bp))
			return 0;
		wrw(bp - 4, bytes);
		wrw(foot_at(bp), bytes);
		wrw(next_bp(bp) - 4, btha_pkg::ALLOC_BIT);
		bp_out = coalesce(bp);
		return 1;
	endfunction

	function automatic void carve(input int unsigned bp, input int unsigned asize);
		int unsigned bs;
		bs = tsize(bp - 4);
		wrw(bp - 4, asize | btha_pkg::ALLOC_BIT);
		wrw(foot_at(bp), asize | btha_pkg::ALLOC_BIT);
		if (asize != bs) begin
			bp = next_bp(bp);
			wrw(bp - 4, bs - asize);
			wrw(foot_at(bp), bs - asize);
		end
	endfunction

	function automatic bit smallest_fit(input int unsigned asize, output int unsigned where);
		longint bp;
		int unsigned s, best;
		bit have;
		bp = 8;
		best = 0;
		have = 0;
		where = 0;
		for (int n = 0; n < btha_pkg::HEAP_WORDS_DEF && bp <= longint'(brk); n++) begin
			s = tsize(int'(bp) - 4);
			if (s == 0)
				break;
			if (talloc(int'(bp) - 4) == 0 && s >= asize && (!have || s < best)) begin
				have = 1;
				best = s;
				where = int'(bp);
			end
			bp += s;
		end
		return have;
	endfunction

	function automatic int unsigned growth_step();
		int unsigned c;
		c = (int'(chunk) + 7) & SIZE_MASK;
		return (c < 16) ? 16 : c;
	endfunction

	function automatic alloc_result_t heap_op(input logic [1:0] op, input logic [17:0] req,
			input logic [17:0] addr);
		alloc_result_t r;
		int unsigned bp, base, asize, c, s;
		r.addr = '0;
		r.st = btha_pkg::ST_OK;
		case (op)
			btha_pkg::OP_INIT: begin
				brk = 0;
				if (!grow_break(16, base)) begin
					r.st = btha_pkg::ST_OOM;
				end else begin
					wrw(base, 0);
					wrw(base + 4, btha_pkg::PROLOGUE_TAG);
					wrw(base + 8, btha_pkg::PROLOGUE_TAG);
					wrw(base + 12, btha_pkg::ALLOC_BIT);
					if (!append_block(growth_step(), bp))
						r.st = btha_pkg::ST_OOM;
				end
			end
			btha_pkg::OP_ALLOC: begin
				if (req == 0) begin
					r.st = btha_pkg::ST_ZERO;
				end else if (brk == 0) begin
					r.st = btha_pkg::ST_OOM;
				end else begin
					asize = (req <= 8) ? 16 : 8 * ((int'(req) + 15) / 8);
					if (smallest_fit(asize, bp)) begin
						carve(bp, asize);
						r.addr = bp[17:0];
					end else begin
						c = growth_step();
						if (append_block((asize > c) ? asize : c, bp)) begin
							carve(bp, asize);
							r.addr = bp[17:0];
						end else begin
							r.st = btha_pkg::ST_OOM;
						end
					end
				end
			end
			btha_pkg::OP_FREE: begin
				if (brk != 0 && addr[2:0] == 0 && addr >= 8 && int'(addr) < brk) begin
					s = tsize(int'(addr) - 4);
					wrw(int'(addr) - 4, s);
					wrw(foot_at(int'(addr)), s);
					void'(coalesce(int'(addr)));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			brk = 0;
			chunk = btha_pkg::CHUNK_RESET;
			results_due.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				chunk = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report($sformatf("unexpected word addr=%0d status=%0d",
						m_tdata[17:0], m_tuser));
				end else begin
					want = results_due.pop_front();
					if (m_tdata[17:0] !== want.addr)
						report($sformatf("result_addr %0d, wanted %0d", m_tdata[17:0], want.addr));
					if (m_tuser !== want.st)
						report($sformatf("status %0d, wanted %0d", m_tuser, want.st));
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(heap_op(s_tuser, s_tdata[17:0], s_tdata[35:18]));
			pending = results_due.size();
		end
	end

endmodule

FILE: verif/tb_boundary_tag_heap_allocator.sv
// Testbench top for the heap allocator: clock, reset, stimulus and verdict.
module tb_boundary_tag_heap_allocator;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [btha_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [1:0]                     s_tuser = btha_pkg::OP_INIT;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [btha_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;
	logic                           cfg_we = 1'b0;
	logic [18:0]                    cfg_wdata = '0;
	int                             errors;
	int                             pending;

	logic [1:0]  ops_sent [$];
	logic [17:0] live_blocks [$];
	int          burst_left = 0;
	bit          hold_req = 0;

	always #6 clk = ~clk;

	boundary_tag_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	heap_alloc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	// Keeps the payload offsets that are currently allocated, so frees hit real blocks.
	always @(posedge clk) begin
		logic [1:0] op;
		if (m_tvalid && m_tready && ops_sent.size() != 0) begin
			op = ops_sent.pop_front();
			if (op == btha_pkg::OP_ALLOC && m_tuser == btha_pkg::ST_OK)
				live_blocks.push_back(m_tdata[17:0]);
		end
		if (s_tvalid && s_tready) begin
			// Results still owed from the old heap must not become frees in the new one.
			if (s_tuser == btha_pkg::OP_INIT) begin
				foreach (ops_sent[i])
					ops_sent[i] = OP_UNUSED;
				live_blocks.delete();
			end
			ops_sent.push_back(s_tuser);
		end
	end

	// Receiver: stall pattern redrawn at random whenever its counter wraps, plus one long hold on request.
	initial begin
		int mode;
		int cnt;
		mode = 0;
		cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (500) @(posedge clk);
			end
			if (cnt == 0)
				mode = $urandom_range(0, 2);
			cnt = (cnt + 1) % 64;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#(12 * 3_000_000);
		$display("status: fail");
		$finish;
	end

	task automatic send(input logic [1:0] op, input logic [17:0] req, input logic [17:0] baddr);
		int gap;
		bit hs;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, baddr, req};
		do begin
			@(negedge clk);
			hs = s_tready;
			@(posedge clk);
		end while (!hs);
		if (op == btha_pkg::OP_INIT)
			live_blocks.delete();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_chunk(input logic [18:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic free_live(input int idx);
		logic [17:0] a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		send(btha_pkg::OP_FREE, 18'($urandom), a);
	endtask

	task automatic random_item();
		int r;
		logic [17:0] req;
		r = $urandom_range(0, 99);
		if (r < 50 || (r < 88 && live_blocks.size() == 0)) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				req = 18'($urandom_range(1, 256));
			else if (r < 95)
				req = 18'($urandom_range(257, 8192));
			else
				req = 18'($urandom);
			send(btha_pkg::OP_ALLOC, req, 18'($urandom));
		end else if (r < 88) begin
			free_live($urandom_range(0, live_blocks.size() - 1));
		end else if (r < 93) begin
			// Misaligned or below the first payload: the block must ignore it.
			req = 18'($urandom);
			if ($urandom_range(0, 1))
				req[2:0] = 3'($urandom_range(1, 7));
			else
				req = 18'($urandom_range(0, 7));
			send(btha_pkg::OP_FREE, 18'($urandom), req);
		end else if (r < 96) begin
			send(OP_UNUSED, 18'($urandom), 18'($urandom));
		end else if (r < 98) begin
			send(btha_pkg::OP_ALLOC, 18'd0, 18'($urandom));
		end else begin
			send(btha_pkg::OP_INIT, 18'($urandom), 18'($urandom));
		end
	endtask

	initial begin
		logic [18:0] chunks [7];
		int n;
		chunks = '{19'd16, 19'd17, 19'd262144, 19'd4096, 19'd24, 19'd1000, 19'd65536};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: requests before the heap exists, then the edges of every operation.
		send(btha_pkg::OP_ALLOC, 18'd5, 18'd0);
		send(btha_pkg::OP_FREE, 18'd0, 18'd64);
		send(btha_pkg::OP_INIT, 18'd0, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd0, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd1, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd8, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd9, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd16, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd100, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'd5000, 18'd0);
		send(btha_pkg::OP_ALLOC, 18'h3FFFF, 18'd0);
		send(btha_pkg::OP_FREE, 18'd0, 18'd0);
		send(btha_pkg::OP_FREE, 18'd0, 18'd4);
		send(btha_pkg::OP_FREE, 18'd0, 18'd13);
		send(btha_pkg::OP_FREE, 18'd0, 18'h3FFF8);
		send(OP_UNUSED, 18'h3FFFF, 18'h3FFFF);
		drain();
		// Free the first and third blocks, then the middle one, which merges both ways.
		free_live(0);
		free_live(1);
		free_live(0);
		send(btha_pkg::OP_ALLOC, 18'd24, 18'd0);
		drain();

		for (int p = 0; p < 7; p++) begin
			set_chunk(chunks[p]);
			send(btha_pkg::OP_INIT, 18'd0, 18'd0);
			if (p == 1)
				hold_req = 1;
			n = (chunks[p] == 19'd262144) ? 60 : 280;
			repeat (n) random_item();
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
